FILE: src/length_prefixed_frame_receiver_defines.svh
// Assertion macros used by the frame receiver checker.
`ifndef LENGTH_PREFIXED_FRAME_RECEIVER_DEFINES_SVH
`define LENGTH_PREFIXED_FRAME_RECEIVER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LPFR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lpfr assertion failed: now");

// Next-cycle implication, disabled while reset is asserted.
`define LPFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lpfr assertion failed: next");

`endif

FILE: src/lpfr_pkg.sv
// Types, codes and constants of the length-prefixed frame receiver.
package lpfr_pkg;

    localparam logic [15:0] LENGTH_FIELD_BYTES = 16'd4;

    // Receive phase codes
    localparam logic [1:0] PH_LEN    = 2'd0;
    localparam logic [1:0] PH_BODY   = 2'd1;
    localparam logic [1:0] PH_BROKEN = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_STORED  = 2'd0;
    localparam logic [1:0] ST_LAST    = 2'd1;
    localparam logic [1:0] ST_REJECT  = 2'd2;
    localparam logic [1:0] ST_DISCARD = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_MIN = 2'd0;
    localparam logic [1:0] CFG_MAX = 2'd1;

    localparam logic [15:0] MIN_RESET = 16'd16;
    localparam logic [15:0] MAX_RESET = 16'd4096;

    typedef struct packed {
        logic [1:0]  phase;
        logic [15:0] byte_count;
        logic [31:0] length_value;
    } lpfr_state_t;

    typedef struct packed {
        logic [31:0] message_length;
        logic [15:0] byte_index;
        logic [1:0]  status;
        logic [7:0]  out_byte;
    } lpfr_result_t;

    localparam lpfr_state_t STATE_RESET = '{phase: PH_LEN, byte_count: 16'd0,
                                            length_value: 32'd0};

endpackage

FILE: src/lpfr_step.sv
// Per-byte deframing step: next state and result for one received byte.
module lpfr_step
    import lpfr_pkg::*;
(
    input  lpfr_state_t  state,
    input  logic [7:0]   rx_byte,
    input  logic [15:0]  min_bytes,
    input  logic [15:0]  max_bytes,
    output lpfr_state_t  state_next,
    output lpfr_result_t result
);

    logic [15:0] count_inc;
    logic [31:0] length_merged;
    logic        length_bad;

    assign count_inc     = state.byte_count + 16'd1;
    // little-endian: byte n of the length field lands in bits 8n+7:8n
    assign length_merged = state.length_value
                         | ({24'd0, rx_byte} << {state.byte_count[1:0], 3'b000});
    assign length_bad    = (state.length_value < {16'd0, min_bytes})
                         || (state.length_value > {16'd0, max_bytes});

    always_comb
    begin
        state_next            = state;
        result.out_byte       = rx_byte;
        result.status         = ST_STORED;
        result.byte_index     = state.byte_count;
        result.message_length = state.length_value;
        case (state.phase)
            PH_LEN:
            begin
                state_next.length_value = length_merged;
                state_next.byte_count   = count_inc;
                result.message_length   = length_merged;
                if (count_inc >= LENGTH_FIELD_BYTES)
                begin
                    state_next.phase = PH_BODY;
                end
            end
            PH_BODY:
            begin
                if (length_bad)
                begin
                    state_next.phase = PH_BROKEN;
                    result.status    = ST_REJECT;
                end
                else if ({16'd0, count_inc} >= state.length_value)
                begin
                    result.status = ST_LAST;
                    state_next    = STATE_RESET;
                end
                else
                begin
                    state_next.byte_count = count_inc;
                end
            end
            default:
            begin
                // broken: drop everything until reset
                result.status     = ST_DISCARD;
                result.byte_index = 16'd0;
            end
        endcase
    end

endmodule

FILE: src/length_prefixed_frame_receiver.sv
// Top level of the length-prefixed frame receiver.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+---------------------------------------------
//  s_*      | in  | s_tvalid/s_tready  | s_tdata[7:0] rx_byte
//  m_*      | out | m_tvalid/m_tready  | m_tdata[7:0] out_byte, [23:8] byte_index,
//           |     |                    |   [55:24] message_length; m_tuser[1:0] status
//  cfg_*    | in  | cfg_we             | cfg_index 0 min, 1 max; cfg_data[15:0]
//
// One item per cycle sustained while m_tready stays high; path: input register, then result register.
// The frame state advances when a byte moves from the input register to the result register.
// A stalled m_tready holds the result; the input register then holds too, and s_tready drops
// only when both are full.
// rst_n clears the frame state to "reading length field" and loads min 16, max 4096.
module length_prefixed_frame_receiver
    import lpfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,    // [7:0] out_byte, [23:8] byte_index, [55:24] message_length
    output logic [1:0]  m_tuser,    // [1:0] status
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic         in_valid_reg;
    logic         in_valid_next;
    logic [7:0]   in_byte_reg;
    logic         out_valid_reg;
    logic         out_valid_next;
    lpfr_result_t out_result_reg;
    lpfr_state_t  state_reg;
    lpfr_state_t  state_next;
    lpfr_result_t step_result;
    logic [15:0]  min_reg;
    logic [15:0]  max_reg;
    logic         advance;

    // move the held byte into the result register when that slot is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    lpfr_step u_step (
        .state      (state_reg),
        .rx_byte    (in_byte_reg),
        .min_bytes  (min_reg),
        .max_bytes  (max_reg),
        .state_next (state_next),
        .result     (step_result)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control state, frame state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_RESET;
            min_reg       <= MIN_RESET;
            max_reg       <= MAX_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MIN: min_reg <= cfg_data;
                    CFG_MAX: max_reg <= cfg_data;
                    default: ;  // drop writes to unknown indexes
                endcase
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
        end
        if (advance)
        begin
            out_result_reg <= step_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_result_reg.message_length, out_result_reg.byte_index,
                       out_result_reg.out_byte};
    assign m_tuser  = out_result_reg.status;

endmodule

FILE: src/lpfr_checker.sv
// Port-level checker for the frame receiver, bound to the top level.
`include "length_prefixed_frame_receiver_defines.svh"

module lpfr_checker
    import lpfr_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // a stalled result holds
    `LPFR_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // discarded bytes carry a zero position
    `LPFR_ASSERT_NOW(a_discard_index, clk, rst_n, m_tvalid && (m_tuser == ST_DISCARD), m_tdata[23:8] == 16'd0)

    // after a rejected length the receiver stays broken
    `LPFR_ASSERT_NEXT(a_reject_sticky, clk, rst_n, m_tvalid && m_tready && (m_tuser == ST_REJECT), !m_tvalid || (m_tuser == ST_DISCARD))

    // once discarding, nothing else is ever delivered
    `LPFR_ASSERT_NEXT(a_discard_sticky, clk, rst_n, m_tvalid && m_tready && (m_tuser == ST_DISCARD), !m_tvalid || (m_tuser == ST_DISCARD))

endmodule

bind length_prefixed_frame_receiver lpfr_checker u_lpfr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

FILE: bench/length_prefixed_frame_receiver_test.sv
// Self-checking testbench for the length-prefixed frame receiver.
module length_prefixed_frame_receiver_test;
    import lpfr_pkg::*;

    // Register indexes past the two limits; writes there must change nothing.
    localparam logic [1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [1:0] CFG_SPARE_HI = 2'd3;

    // Input register plus result register, with a little margin.
    localparam int SETTLE_CYCLES = 4;
    localparam int MAX_REPORTS   = 10;
    localparam int HOLD_OFF_CYCLES = 80;
    // Frame length of the long-frame test, with both limits pinned to it.
    localparam logic [15:0] LONG_FRAME_BYTES = 16'd170;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'd0;      // [7:0] rx_byte
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [55:0] m_tdata;               // [7:0] out_byte, [23:8] byte_index, [55:24] message_length
    logic [1:0]  m_tuser;               // [1:0] status
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = CFG_MIN;
    logic [15:0] cfg_data  = 16'd0;

    // Shadow copy of the deframer state and its limits.
    lpfr_state_t frame_state = STATE_RESET;
    logic [15:0] limit_min   = MIN_RESET;
    logic [15:0] limit_max   = MAX_RESET;

    // Results still owed by the block, oldest first.
    lpfr_result_t expected_items[$];

    int unsigned mismatch_count   = 0;
    bit          idle_on          = 1'b0;
    int unsigned hold_off_request = 0;

    always #2 clk = ~clk;

    length_prefixed_frame_receiver dut (.*);

    // Advance the shadow deframer by one received byte and return the result it owes.
    function automatic lpfr_result_t deframe_byte(input logic [7:0] value);
        lpfr_result_t r;
        r.out_byte = value;
        case (frame_state.phase)
            PH_LEN:
            begin
                // Little-endian: byte n of the length field fills bits 8n upward.
                r.byte_index = frame_state.byte_count;
                r.status     = ST_STORED;
                frame_state.length_value |= 32'(value) << (8 * frame_state.byte_count[1:0]);
                frame_state.byte_count = frame_state.byte_count + 16'd1;
                if (frame_state.byte_count >= LENGTH_FIELD_BYTES)
                    frame_state.phase = PH_BODY;
                r.message_length = frame_state.length_value;
            end
            PH_BODY:
            begin
                r.byte_index     = frame_state.byte_count;
                r.message_length = frame_state.length_value;
                if (frame_state.length_value < 32'(limit_min) ||
                    frame_state.length_value > 32'(limit_max))
                begin
                    // Bad length: drop the byte and stick in the broken phase.
                    frame_state.phase = PH_BROKEN;
                    r.status          = ST_REJECT;
                end
                else
                begin
                    frame_state.byte_count = frame_state.byte_count + 16'd1;
                    if (32'(frame_state.byte_count) >= frame_state.length_value)
                    begin
                        // Last byte; a length no longer than the field ends on the first body byte.
                        r.status    = ST_LAST;
                        frame_state = STATE_RESET;
                    end
                    else
                        r.status = ST_STORED;
                end
            end
            default:
            begin
                // Broken (and the unused code): discard, report the rejected length.
                r.status         = ST_DISCARD;
                r.byte_index     = 16'd0;
                r.message_length = frame_state.length_value;
            end
        endcase
        return r;
    endfunction

    function automatic void report_mismatch(input string what, input logic [31:0] want,
                                            input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch in %s: expected %0h, got %0h", what, want, got);
    endfunction

    // Compare every accepted result against the oldest owed one, field by field.
    always @(posedge clk)
    begin : result_check
        lpfr_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_items.size() == 0)
                report_mismatch("result with nothing owed", 32'd0, 32'(m_tdata[7:0]));
            else
            begin
                want = expected_items.pop_front();
                if (m_tdata[7:0] !== want.out_byte)
                    report_mismatch("out_byte", 32'(want.out_byte), 32'(m_tdata[7:0]));
                if (m_tuser !== want.status)
                    report_mismatch("status", 32'(want.status), 32'(m_tuser));
                if (m_tdata[23:8] !== want.byte_index)
                    report_mismatch("byte_index", 32'(want.byte_index), 32'(m_tdata[23:8]));
                if (m_tdata[55:24] !== want.message_length)
                    report_mismatch("message_length", want.message_length, m_tdata[55:24]);
            end
        end
    end

    // Receiver side: random stall bursts, plus a long hold-off on request.
    initial
    begin : result_sink
        int unsigned stall;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_request != 0)
            begin
                stall            = hold_off_request;
                hold_off_request = 0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
                stall = $urandom_range(1, 15);
            else
                stall = 0;
            if (stall != 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    // Offer one byte, hold it until taken, then record what it owes.
    task automatic send_byte(input logic [7:0] value);
        int unsigned gap;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 15);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        expected_items.push_back(deframe_byte(value));
    endtask

    task automatic send_length_field(input logic [31:0] length);
        for (int i = 0; i < 4; i++)
            send_byte(length[8 * i +: 8]);
    endtask

    task automatic send_body(input int unsigned count);
        repeat (count) send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic send_frame(input logic [31:0] length);
        send_length_field(length);
        send_body((length <= 32'(LENGTH_FIELD_BYTES)) ? 1 : length - 32'(LENGTH_FIELD_BYTES));
    endtask

    // Drop valid and wait until every owed result has come back and the pipe is empty.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_items.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Call only with the block drained.
    task automatic write_limit(input logic [1:0] index, input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (index == CFG_MIN)
            limit_min = value;
        else if (index == CFG_MAX)
            limit_max = value;
    endtask

    // Pick an accepted length, biased toward the short end and the two limits.
    function automatic logic [31:0] pick_length();
        int unsigned span;
        span = (limit_max - limit_min) / 4;
        case ($urandom_range(0, 5))
            0:       return 32'(limit_min);
            1:       return 32'(limit_max);
            default: return $urandom_range(limit_min, limit_min + span);
        endcase
    endfunction

    // Shortest frame allowed by the reset limits, body opening with both byte extremes.
    task automatic test_reset_limits();
        idle_on = 1'b1;
        send_length_field(32'(MIN_RESET));
        send_byte(8'h00);
        send_byte(8'hFF);
        send_body(MIN_RESET - LENGTH_FIELD_BYTES - 2);
        wait_drained();
    endtask

    // Lengths not above the field size end on the first body byte.
    task automatic test_short_lengths();
        write_limit(CFG_MIN, 16'h0000);
        write_limit(CFG_MAX, 16'd8);
        send_frame(32'd0);
        send_frame(32'd4);
        wait_drained();
    endtask

    // Back-to-back frames under one pair of limits; spare registers get junk.
    task automatic test_random_frames(input logic [15:0] lo, input logic [15:0] hi,
                                      input int unsigned frames);
        write_limit(CFG_MIN, lo);
        write_limit(CFG_MAX, hi);
        write_limit(CFG_SPARE_LO, 16'($urandom));
        write_limit(CFG_SPARE_HI, 16'($urandom));
        repeat (frames)
        begin
            idle_on = ($urandom_range(0, 3) != 0);
            send_frame(pick_length());
            // Now and then pause the sender until everything has come back.
            if ($urandom_range(0, 5) == 0)
                wait_drained();
        end
        wait_drained();
    endtask

    // Hold the receiver off while bytes keep coming, so the input side stalls.
    task automatic test_output_backpressure();
        idle_on          = 1'b0;
        hold_off_request = HOLD_OFF_CYCLES;
        send_frame(32'(limit_max));
        wait_drained();
    endtask

    // Frame of LONG_FRAME_BYTES with both limits pinned to its length.
    task automatic test_longest_frame();
        write_limit(CFG_MAX, LONG_FRAME_BYTES);
        write_limit(CFG_MIN, LONG_FRAME_BYTES);
        idle_on = 1'b0;
        send_frame(32'(LONG_FRAME_BYTES));
        wait_drained();
    endtask

    // Minimum above maximum rejects everything; the block then stays broken for good.
    task automatic test_rejected_length();
        write_limit(CFG_MIN, 16'hFFFF);
        write_limit(CFG_MAX, 16'd5);
        idle_on = 1'b1;
        send_length_field(32'hFFFF_FFFF);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_body(20);
        wait_drained();
        // Relaxing the limits must not revive it; finish with no idling.
        write_limit(CFG_MIN, 16'd5);
        write_limit(CFG_MAX, 16'hFFFF);
        idle_on = 1'b0;
        send_frame(32'd16);
        wait_drained();
    endtask

    initial
    begin : run
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_limits();
        test_short_lengths();
        test_random_frames(16'd5, 16'd64, 18);
        test_output_backpressure();
        test_random_frames(16'd40, 16'd200, 4);
        test_random_frames(16'd5, 16'd20, 15);
        test_longest_frame();
        test_rejected_length();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_items.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Stop a hung run.
    initial
    begin : watchdog
        #(4 * 600000);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
